// File: rtl/core/htab_pkg.sv
`default_nettype none
package htab_pkg;

    localparam int NUM_HANDLES = 64;
    localparam int IDX_W       = (NUM_HANDLES > 1) ? $clog2(NUM_HANDLES) : 1;
    localparam int HANDLE_W    = 8;
    localparam int REF_W       = 64;
    localparam int REQ_W       = 2;

    // lowest-free search: groups of GROUP_W bits, then a pick over the groups
    localparam int GROUP_W     = 8;
    localparam int GIDX_W      = $clog2(GROUP_W);
    localparam int NUM_GROUPS  = (NUM_HANDLES + GROUP_W - 1) / GROUP_W;
    localparam int PAD_W       = NUM_GROUPS * GROUP_W;

    localparam int S_DATA_W    = 72;   // handle, obj_ref
    localparam int M_DATA_W    = 80;   // status, handle_out, obj_out, pad

    localparam logic [HANDLE_W-1:0] FAIL_HANDLE = '1;
    localparam logic                ST_OK       = 1'b0;
    localparam logic                ST_FAIL     = 1'b1;

    typedef enum logic [REQ_W-1:0] {
        REQ_FIND = 2'd0,
        REQ_ADD  = 2'd1,
        REQ_DEL  = 2'd2,
        REQ_GET  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic load_in;
        logic scan;
        logic exec;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_stat_t;

endpackage
`default_nettype wire

// File: rtl/core/handle_table_allocator.sv
`default_nettype none
// Handle table of htab_pkg::NUM_HANDLES slots mapping small handles to 64-bit
// object references. Requests (tuser): find lowest free slot, add a reference
// in the lowest free slot, delete a handle, get a handle's reference. Each
// word gives one result word; failure (table full, handle out of range or
// slot empty) returns status 1 and handle -1. Adding a null reference reports
// the free handle but leaves the slot empty. One request is in work at a
// time: accept, then the grouped lowest-free search and the registered
// table read, then resolve and write the output register once it is free.
// The next request is accepted while a result still waits in the output
// register. Occupancy is cleared at reset.
module handle_table_allocator (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [7:0] handle, [71:8] obj_ref
    input  wire logic [htab_pkg::S_DATA_W-1:0]   s_tdata,
    // [1:0] req_type
    input  wire logic [htab_pkg::REQ_W-1:0]      s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [0] status, [8:1] handle_out, [72:9] obj_out, [79:73] zero
    output logic [htab_pkg::M_DATA_W-1:0]        m_tdata
);
    import htab_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    htab_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    htab_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire

// File: rtl/core/htab_ctrl.sv
`default_nettype none
module htab_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire htab_pkg::dp_stat_t stat,
    output htab_pkg::dp_cmd_t       cmd
);
    import htab_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready    = 1'b0;
        cmd.load_in = 1'b0;
        cmd.scan    = 1'b0;
        cmd.exec    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ST_EXEC:
            begin
                cmd.exec = stat.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/core/htab_datapath.sv
`default_nettype none
module htab_datapath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire htab_pkg::dp_cmd_t               cmd,
    output htab_pkg::dp_stat_t                   stat,
    input  wire logic [htab_pkg::S_DATA_W-1:0]   s_tdata,
    input  wire logic [htab_pkg::REQ_W-1:0]      s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [htab_pkg::M_DATA_W-1:0]        m_tdata
);
    import htab_pkg::*;

    // request latch
    req_t                req_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [REF_W-1:0]    ref_reg;

    // occupancy and reference store
    logic [NUM_HANDLES-1:0] valid_reg;
    logic [NUM_HANDLES-1:0] valid_next;
    logic [REF_W-1:0]       slot_ref [NUM_HANDLES];
    logic [REF_W-1:0]       rd_data_reg;

    // first search stage
    logic [NUM_GROUPS-1:0] grp_free_reg;
    logic [NUM_GROUPS-1:0] grp_free_next;
    logic [GIDX_W-1:0]     grp_idx_reg  [NUM_GROUPS];
    logic [GIDX_W-1:0]     grp_idx_next [NUM_GROUPS];
    logic [PAD_W-1:0]      valid_pad;

    // result
    logic                  out_valid_reg;
    logic                  status_reg;
    logic [HANDLE_W-1:0]   hout_reg;
    logic [REF_W-1:0]      obj_reg;

    logic                  free_found;
    logic [HANDLE_W-1:0]   free_handle;
    logic [IDX_W-1:0]      free_idx;
    logic                  in_range;
    logic [IDX_W-1:0]      h_idx;
    logic                  h_valid;
    logic                  res_status;
    logic [HANDLE_W-1:0]   res_handle;
    logic [REF_W-1:0]      res_obj;
    logic                  do_write;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            req_reg    <= req_t'(s_tuser);
            handle_reg <= s_tdata[HANDLE_W-1:0];
            ref_reg    <= s_tdata[HANDLE_W +: REF_W];
        end
    end

    // pad slots past the table as occupied so they are never picked
    always_comb
    begin
        valid_pad                  = '1;
        valid_pad[NUM_HANDLES-1:0] = valid_reg;
    end

    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            grp_free_next[g] = 1'b0;
            grp_idx_next[g]  = '0;
            for (int b = GROUP_W - 1; b >= 0; b--)
            begin
                if (!valid_pad[g*GROUP_W + b])
                begin
                    grp_free_next[g] = 1'b1;
                    grp_idx_next[g]  = GIDX_W'(b);
                end
            end
        end
    end

    assign in_range = (handle_reg < HANDLE_W'(NUM_HANDLES));
    assign h_idx    = handle_reg[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.scan)
        begin
            grp_free_reg <= grp_free_next;
            for (int g = 0; g < NUM_GROUPS; g++)
            begin
                grp_idx_reg[g] <= grp_idx_next[g];
            end
            rd_data_reg <= slot_ref[h_idx];
        end
    end

    always_comb
    begin
        free_found  = 1'b0;
        free_handle = '0;
        for (int g = NUM_GROUPS - 1; g >= 0; g--)
        begin
            if (grp_free_reg[g])
            begin
                free_found  = 1'b1;
                free_handle = HANDLE_W'(g*GROUP_W) + HANDLE_W'(grp_idx_reg[g]);
            end
        end
    end

    assign free_idx = free_handle[IDX_W-1:0];
    assign h_valid  = in_range && valid_reg[h_idx];

    always_comb
    begin
        res_status = ST_FAIL;
        res_handle = FAIL_HANDLE;
        res_obj    = '0;
        do_write   = 1'b0;
        valid_next = valid_reg;
        unique case (req_reg)
            REQ_FIND:
            begin
                if (free_found)
                begin
                    res_status = ST_OK;
                    res_handle = free_handle;
                end
            end
            REQ_ADD:
            begin
                if (free_found)
                begin
                    res_status = ST_OK;
                    res_handle = free_handle;
                    // a null reference leaves the slot empty
                    if (ref_reg != '0)
                    begin
                        do_write             = 1'b1;
                        valid_next[free_idx] = 1'b1;
                    end
                end
            end
            REQ_DEL:
            begin
                if (h_valid)
                begin
                    res_status        = ST_OK;
                    res_handle        = handle_reg;
                    valid_next[h_idx] = 1'b0;
                end
            end
            REQ_GET:
            begin
                if (h_valid)
                begin
                    res_status = ST_OK;
                    res_handle = handle_reg;
                    res_obj    = rd_data_reg;
                end
            end
            default:
            begin
                res_status = ST_FAIL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.exec)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && do_write)
        begin
            slot_ref[free_idx] <= ref_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.exec)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            status_reg <= res_status;
            hout_reg   <= res_handle;
            obj_reg    <= res_obj;
        end
    end

    assign stat.out_free = !out_valid_reg || m_tready;
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = {{(M_DATA_W - 1 - HANDLE_W - REF_W){1'b0}},
                            obj_reg, hout_reg, status_reg};

endmodule
`default_nettype wire

// File: tb/handle_table_allocator_test.sv
`timescale 1ns / 100ps

module handle_table_allocator_test;
    import htab_pkg::*;

    localparam int RANDOM_ITEMS = 1850;
    localparam int CALM_ITEMS   = 200;
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 20;
    localparam logic [REF_W-1:0] ONES = '1;

    typedef struct packed {
        logic                status;
        logic [HANDLE_W-1:0] handle_out;
        logic [REF_W-1:0]    obj_out;
    } result_t;

    typedef struct {
        req_t                req;
        logic [HANDLE_W-1:0] handle;
        logic [REF_W-1:0]    obj;
        bit                  fixed;    // want is typed in, not predicted
        result_t             want;
    } row_t;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } mix_t;

    localparam result_t NO_SUCH = '{ST_FAIL, FAIL_HANDLE, 64'h0};
    localparam result_t ANY     = '0;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;     // [7:0] handle, [71:8] obj_ref
    logic [REQ_W-1:0]    s_tuser;     // [1:0] req_type
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;     // [0] status, [8:1] handle_out, [72:9] obj_out

    // shadow of the table
    logic [NUM_HANDLES-1:0] occupied;
    logic [REF_W-1:0]       stored_ref [NUM_HANDLES];

    result_t pending_results [$];
    result_t head;
    row_t    script [25];
    int      faults = 0;
    int      idle_cycles = 0;
    bit      calm = 1'b0;

    handle_table_allocator DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 clk = ~clk;

    function automatic result_t resolve_request(req_t r, logic [HANDLE_W-1:0] h,
                                                logic [REF_W-1:0] o);
        result_t res;
        int      slot;
        logic    hit;
        res  = NO_SUCH;
        slot = -1;
        for (int i = NUM_HANDLES - 1; i >= 0; i--)
            if (!occupied[i])
                slot = i;
        hit = (h < NUM_HANDLES) ? occupied[h[IDX_W-1:0]] : 1'b0;
        case (r) inside
            REQ_FIND, REQ_ADD:
            begin
                if (slot >= 0)
                begin
                    res.status     = ST_OK;
                    res.handle_out = HANDLE_W'(slot);
                    // a null reference reports the slot but leaves it empty
                    if (r == REQ_ADD && o != '0)
                    begin
                        occupied[slot]   = 1'b1;
                        stored_ref[slot] = o;
                    end
                end
            end
            REQ_DEL:
            begin
                if (hit)
                begin
                    occupied[h[IDX_W-1:0]] = 1'b0;
                    res.status     = ST_OK;
                    res.handle_out = h;
                end
            end
            default:
            begin
                if (hit)
                begin
                    res.status     = ST_OK;
                    res.handle_out = h;
                    res.obj_out    = stored_ref[h[IDX_W-1:0]];
                end
            end
        endcase
        return res;
    endfunction

    function automatic req_t pick_request(mix_t m);
        int roll;
        roll = $urandom_range(0, 99);
        case (m)
            MIX_FILL:
                return req_t'(roll < 70 ? REQ_ADD : roll < 80 ? REQ_FIND :
                              roll < 92 ? REQ_GET : REQ_DEL);
            MIX_DRAIN:
                return req_t'(roll < 60 ? REQ_DEL : roll < 80 ? REQ_GET :
                              roll < 90 ? REQ_FIND : REQ_ADD);
            default:
                return req_t'(roll % 4);
        endcase
    endfunction

    // mostly live handles, some empty ones, some negative or out of range
    function automatic logic [HANDLE_W-1:0] pick_handle();
        int live [$];
        int roll;
        roll = $urandom_range(0, 99);
        for (int i = 0; i < NUM_HANDLES; i++)
            if (occupied[i])
                live.push_back(i);
        if (roll < 60 && live.size() != 0)
            return HANDLE_W'(live[$urandom_range(0, live.size() - 1)]);
        if (roll < 80)
            return HANDLE_W'($urandom_range(0, NUM_HANDLES - 1));
        return HANDLE_W'($urandom);
    endfunction

    function automatic logic [REF_W-1:0] pick_ref();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return '0;
        if (roll < 12)
            return ONES;
        return {$urandom, $urandom};
    endfunction

    // called at a rising edge; leaves tvalid high so back-to-back words need no toggle
    task automatic push_word(input req_t r, input logic [HANDLE_W-1:0] h,
                             input logic [REF_W-1:0] o, input bit fixed,
                             input result_t want);
        result_t predicted;
        s_tvalid <= 1'b1;
        s_tuser  <= r;
        s_tdata  <= {o, h};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = resolve_request(r, h, o);
        pending_results.push_back(fixed ? want : predicted);
    endtask

    task automatic hold_off(input int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic maybe_gap();
        if (!calm && $urandom_range(0, 4) == 0)
            hold_off($urandom_range(1, 6));
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    initial
    begin
        mix_t                mix;
        int                  sent;
        int                  span;
        req_t                r;
        logic [HANDLE_W-1:0] h;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= REQ_FIND;
        occupied = '0;
        script = '{
            '{REQ_FIND, 8'h00, 64'h0, 1'b1, '{ST_OK, 8'h00, 64'h0}},
            '{REQ_GET,  8'h00, 64'h0, 1'b1, NO_SUCH},
            '{REQ_DEL,  8'h00, 64'h0, 1'b1, NO_SUCH},
            '{REQ_ADD,  8'hAA, 64'h0, 1'b1, '{ST_OK, 8'h00, 64'h0}},
            '{REQ_FIND, 8'h00, 64'h0, 1'b1, '{ST_OK, 8'h00, 64'h0}},
            '{REQ_ADD,  8'h80, ONES,  1'b1, '{ST_OK, 8'h00, 64'h0}},
            '{REQ_ADD,  8'h7F, 64'h1, 1'b1, '{ST_OK, 8'h01, 64'h0}},
            '{REQ_FIND, 8'hFF, ONES,  1'b1, '{ST_OK, 8'h02, 64'h0}},
            '{REQ_GET,  8'h00, 64'h5, 1'b1, '{ST_OK, 8'h00, ONES}},
            '{REQ_GET,  8'h01, 64'h0, 1'b1, '{ST_OK, 8'h01, 64'h1}},
            '{REQ_GET,  8'h80, 64'h0, 1'b1, NO_SUCH},
            '{REQ_GET,  8'hFF, 64'h0, 1'b1, NO_SUCH},
            '{REQ_GET,  8'h7F, 64'h0, 1'b1, NO_SUCH},
            '{REQ_GET,  8'h40, 64'h0, 1'b1, NO_SUCH},
            '{REQ_GET,  8'h3F, 64'h0, 1'b1, NO_SUCH},
            '{REQ_DEL,  8'h40, 64'h0, 1'b1, NO_SUCH},
            '{REQ_DEL,  8'h80, 64'h0, 1'b1, NO_SUCH},
            '{REQ_DEL,  8'hFF, 64'h0, 1'b1, NO_SUCH},
            '{REQ_DEL,  8'h00, 64'h0, 1'b1, '{ST_OK, 8'h00, 64'h0}},
            '{REQ_GET,  8'h00, 64'h0, 1'b1, NO_SUCH},
            '{REQ_DEL,  8'h00, 64'h0, 1'b1, NO_SUCH},
            '{REQ_ADD,  8'h00, 64'h8000_0000_0000_0000, 1'b1, '{ST_OK, 8'h00, 64'h0}},
            '{REQ_GET,  8'h00, 64'h0, 1'b0, ANY},
            '{REQ_ADD,  8'h00, 64'hA5A5_5A5A_F00F_0FF0, 1'b0, ANY},
            '{REQ_DEL,  8'h01, 64'h0, 1'b0, ANY}
        };
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            maybe_gap();
            push_word(script[i].req, script[i].handle, script[i].obj,
                      script[i].fixed, script[i].want);
        end
        settle();

        // phases that fill, drain or churn the table
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            mix  = mix_t'($urandom_range(0, 2));
            span = $urandom_range(30, 160);
            for (int k = 0; k < span && sent < RANDOM_ITEMS; k++)
            begin
                if (sent == RANDOM_ITEMS / 2)
                    settle();
                if (sent == RANDOM_ITEMS - CALM_ITEMS)
                    calm = 1'b1;
                maybe_gap();
                r = pick_request(mix);
                h = (r == REQ_DEL || r == REQ_GET) ? pick_handle() : HANDLE_W'($urandom);
                push_word(r, h, pick_ref(), 1'b0, ANY);
                sent++;
            end
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (faults == 0)
            $display("[handle_table_allocator] OK");
        else
            $display("[handle_table_allocator] ERROR");
        $finish;
    end

    initial
    begin
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                if (faults < 10)
                    $display("unexpected result word: %h", m_tdata);
                faults++;
            end
            else
            begin
                head = pending_results.pop_front();
                if (m_tdata[0] !== head.status || m_tdata[8:1] !== head.handle_out
                    || m_tdata[72:9] !== head.obj_out)
                begin
                    if (faults < 10)
                        $display("mismatch: expected %0d %0d %h, got %0d %0d %h",
                                 head.status, $signed(head.handle_out), head.obj_out,
                                 m_tdata[0], $signed(m_tdata[8:1]), m_tdata[72:9]);
                    faults++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid === 1'b1 && s_tready === 1'b1)
            || (m_tvalid === 1'b1 && m_tready === 1'b1))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT)
        begin
            $display("[handle_table_allocator] ERROR");
            $finish;
        end
    end

endmodule

// File: files.f
rtl/core/htab_pkg.sv
rtl/core/htab_ctrl.sv
rtl/core/htab_datapath.sv
rtl/core/handle_table_allocator.sv
tb/handle_table_allocator_test.sv
